>>> rtl/osd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package osd_pkg;

  localparam int unsigned DIST_W = 16;
  localparam int unsigned DEG_W  = 9;
  localparam int unsigned CODE_W = 3;
  localparam int unsigned FLAG_W = 4;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned LANES  = 4;

  typedef logic [2:0] lvl_t;

  localparam lvl_t LVL_0     = 3'd0;
  localparam lvl_t LVL_1     = 3'd1;
  localparam lvl_t LVL_2     = 3'd2;
  localparam lvl_t LVL_3     = 3'd3;
  localparam lvl_t LVL_CLEAR = 3'd4;

  localparam logic [CODE_W-1:0] SPD_STOP    = 3'd0;
  localparam logic [CODE_W-1:0] SPD_CRAWL   = 3'd1;
  localparam logic [CODE_W-1:0] SPD_MID     = 3'd2;
  localparam logic [CODE_W-1:0] SPD_TOP     = 3'd4;
  localparam logic [CODE_W-1:0] SPD_REVERSE = 3'd5;

  localparam logic [CODE_W-1:0] STR_STRAIGHT    = 3'd0;
  localparam logic [CODE_W-1:0] STR_SOFT_RIGHT  = 3'd1;
  localparam logic [CODE_W-1:0] STR_MED_RIGHT   = 3'd2;
  localparam logic [CODE_W-1:0] STR_SHARP_RIGHT = 3'd3;
  localparam logic [CODE_W-1:0] STR_SOFT_LEFT   = 3'd4;
  localparam logic [CODE_W-1:0] STR_MED_LEFT    = 3'd5;
  localparam logic [CODE_W-1:0] STR_SHARP_LEFT  = 3'd6;
  localparam logic [CODE_W-1:0] STR_LEFT_OFS    = 3'd3;

  // Lane order
  localparam int unsigned LANE_FRONT = 0;
  localparam int unsigned LANE_LEFT  = 1;
  localparam int unsigned LANE_RIGHT = 2;
  localparam int unsigned LANE_BACK  = 3;

  typedef enum logic [2:0] {
    REG_CLEAR,
    REG_LVL3,
    REG_LVL2,
    REG_LVL1,
    REG_NAV_MODE,
    REG_FAR,
    REG_MID,
    REG_STOP
  } reg_idx_t;

  typedef struct packed {
    logic [DIST_W-1:0] clear_thr;
    logic [DIST_W-1:0] lvl3_thr;
    logic [DIST_W-1:0] lvl2_thr;
    logic [DIST_W-1:0] lvl1_thr;
  } thr_t;

  typedef struct packed {
    logic [DIST_W-1:0] far_dist;
    logic [DIST_W-1:0] mid_dist;
    logic [DIST_W-1:0] stop_dist;
  } nav_cfg_t;

  typedef struct packed {
    lvl_t front;
    lvl_t left;
    lvl_t right;
    lvl_t back;
  } lvl_set_t;

  typedef struct packed {
    logic [CODE_W-1:0] speed;
    logic [CODE_W-1:0] steer;
  } drive_t;

endpackage

`default_nettype wire

>>> rtl/osd_grade_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module osd_grade_lane (
  input  wire logic [osd_pkg::DIST_W-1:0] dist_cm,
  input  osd_pkg::thr_t                   thr,
  output osd_pkg::lvl_t                   lvl
);
  import osd_pkg::*;

  always_comb begin
    if (dist_cm >= thr.clear_thr) begin
      lvl = LVL_CLEAR;
    end else if (dist_cm >= thr.lvl3_thr) begin
      lvl = LVL_3;
    end else if (dist_cm >= thr.lvl2_thr) begin
      lvl = LVL_2;
    end else if (dist_cm >= thr.lvl1_thr) begin
      lvl = LVL_1;
    end else begin
      lvl = LVL_0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/osd_nav.sv
`timescale 1ns / 1ps
`default_nettype none

module osd_nav (
  input  wire logic [osd_pkg::DEG_W-1:0]  heading,
  input  wire logic [osd_pkg::DEG_W-1:0]  bearing,
  input  wire logic [osd_pkg::DIST_W-1:0] dist_m,
  input  osd_pkg::nav_cfg_t               cfg,
  output osd_pkg::drive_t                 drive
);
  import osd_pkg::*;

  localparam int unsigned DIFF_W = DEG_W + 2;

  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] wrapped;

  assign diff = $signed({2'b00, heading}) - $signed({2'b00, bearing});

  always_comb begin
    if (diff > 11'sd180) begin
      wrapped = diff - 11'sd360;
    end else if (diff < -11'sd180) begin
      wrapped = diff + 11'sd360;
    end else begin
      wrapped = diff;
    end

    if (wrapped > 11'sd60) begin
      drive.steer = STR_SHARP_RIGHT;
    end else if (wrapped > 11'sd45) begin
      drive.steer = STR_MED_RIGHT;
    end else if (wrapped > 11'sd30) begin
      drive.steer = STR_SOFT_RIGHT;
    end else if (wrapped < -11'sd60) begin
      drive.steer = STR_SHARP_LEFT;
    end else if (wrapped < -11'sd45) begin
      drive.steer = STR_MED_LEFT;
    end else if (wrapped < -11'sd30) begin
      drive.steer = STR_SOFT_LEFT;
    end else begin
      drive.steer = STR_STRAIGHT;
    end

    // between stop and mid the car also halts
    if (dist_m > cfg.far_dist) begin
      drive.speed = SPD_TOP;
    end else if (dist_m > cfg.mid_dist) begin
      drive.speed = SPD_MID;
    end else begin
      drive.speed = SPD_STOP;
    end
  end

endmodule

`default_nettype wire

>>> rtl/osd_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module osd_merge (
  input  osd_pkg::lvl_set_t                lvls,
  input  osd_pkg::drive_t                  nav,
  input  wire logic                        nav_mode,
  output osd_pkg::drive_t                  drive,
  output logic [osd_pkg::FLAG_W-1:0]       flags
);
  import osd_pkg::*;

  lvl_t              near;
  lvl_t              near_fl;
  logic [CODE_W-1:0] strength;

  assign flags = {lvls.back  != LVL_CLEAR, lvls.right != LVL_CLEAR,
                  lvls.left  != LVL_CLEAR, lvls.front != LVL_CLEAR};

  assign near_fl  = (lvls.left < lvls.front) ? lvls.left : lvls.front;
  assign near     = (lvls.right < near_fl) ? lvls.right : near_fl;
  assign strength = LVL_3 - near;

  always_comb begin
    if (lvls.front == LVL_CLEAR && lvls.left == LVL_CLEAR && lvls.right == LVL_CLEAR) begin
      if (nav_mode) begin
        drive = nav;
      end else begin
        drive.speed = SPD_TOP;
        drive.steer = STR_STRAIGHT;
      end
    end else if (lvls.front <= LVL_1 && lvls.left <= LVL_1 && lvls.right <= LVL_1) begin
      if (lvls.back > LVL_2) begin
        drive.speed = SPD_REVERSE;
        drive.steer = STR_MED_RIGHT;
      end else begin
        drive.speed = SPD_STOP;
        drive.steer = STR_STRAIGHT;
      end
    end else begin
      drive.speed = (near == LVL_0) ? SPD_CRAWL : near;
      if (near >= LVL_3) begin
        drive.steer = STR_STRAIGHT;
      end else if (lvls.right >= lvls.front && lvls.right >= lvls.left) begin
        drive.steer = strength;
      end else if (lvls.left >= lvls.front && lvls.left >= lvls.right) begin
        drive.steer = strength + STR_LEFT_OFS;
      end else begin
        drive.steer = STR_STRAIGHT;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/obstacle_steer_decision_core.sv
// Channel   Direction  Handshake            Payload
// in_       sink       in_valid/in_stall    four distances, heading, bearing, target
// out_      source     out_valid/out_stall  speed_code, steer_code, obstacle_flags
// cfg_      APB slave  psel/penable/pready  8 registers at byte address 4*i
//
// Two register stages: four grading lanes and the navigation unit, then the merge.
// One transaction per cycle unless stalled; out_valid rises after both stages load.
// Reset clears both valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline; in_stall follows out_stall then.
`timescale 1ns / 1ps
`default_nettype none

module obstacle_steer_decision_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [osd_pkg::DIST_W-1:0]    in_front_distance_cm,
  input  wire logic [osd_pkg::DIST_W-1:0]    in_left_distance_cm,
  input  wire logic [osd_pkg::DIST_W-1:0]    in_right_distance_cm,
  input  wire logic [osd_pkg::DIST_W-1:0]    in_back_distance_cm,
  input  wire logic [osd_pkg::DEG_W-1:0]     in_target_heading_deg,
  input  wire logic [osd_pkg::DEG_W-1:0]     in_current_bearing_deg,
  input  wire logic [osd_pkg::DIST_W-1:0]    in_target_distance_m,

  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [osd_pkg::CODE_W-1:0]         out_speed_code,
  output logic [osd_pkg::CODE_W-1:0]         out_steer_code,
  output logic [osd_pkg::FLAG_W-1:0]         out_obstacle_flags,

  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [osd_pkg::ADDR_W-1:0]    cfg_paddr,
  input  wire logic [osd_pkg::DATA_W-1:0]    cfg_pwdata,
  output logic [osd_pkg::DATA_W-1:0]         cfg_prdata,
  output logic                               cfg_pready
);
  import osd_pkg::*;

  thr_t              thr_r;
  nav_cfg_t          nav_cfg_r;
  logic              nav_mode_r;
  reg_idx_t          reg_idx;
  logic              cfg_wr;

  logic [DIST_W-1:0] lane_dist [LANES];
  lvl_t              lane_lvl  [LANES];
  lvl_set_t          lvls;
  drive_t            nav_drive;

  logic              advance;
  logic              s1_valid_r;
  lvl_set_t          s1_lvls_r;
  drive_t            s1_nav_r;

  drive_t            mrg_drive;
  logic [FLAG_W-1:0] mrg_flags;

  logic              out_valid_r;
  drive_t            out_drive_r;
  logic [FLAG_W-1:0] out_flags_r;

  // configuration
  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.clear_thr     <= 16'd150;
      thr_r.lvl3_thr      <= 16'd100;
      thr_r.lvl2_thr      <= 16'd75;
      thr_r.lvl1_thr      <= 16'd50;
      nav_mode_r          <= 1'b0;
      nav_cfg_r.far_dist  <= 16'd100;
      nav_cfg_r.mid_dist  <= 16'd50;
      nav_cfg_r.stop_dist <= 16'd10;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_CLEAR:    thr_r.clear_thr     <= cfg_pwdata[DIST_W-1:0];
        REG_LVL3:     thr_r.lvl3_thr      <= cfg_pwdata[DIST_W-1:0];
        REG_LVL2:     thr_r.lvl2_thr      <= cfg_pwdata[DIST_W-1:0];
        REG_LVL1:     thr_r.lvl1_thr      <= cfg_pwdata[DIST_W-1:0];
        REG_NAV_MODE: nav_mode_r          <= cfg_pwdata[0];
        REG_FAR:      nav_cfg_r.far_dist  <= cfg_pwdata[DIST_W-1:0];
        REG_MID:      nav_cfg_r.mid_dist  <= cfg_pwdata[DIST_W-1:0];
        REG_STOP:     nav_cfg_r.stop_dist <= cfg_pwdata[DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CLEAR:    cfg_prdata = {16'd0, thr_r.clear_thr};
      REG_LVL3:     cfg_prdata = {16'd0, thr_r.lvl3_thr};
      REG_LVL2:     cfg_prdata = {16'd0, thr_r.lvl2_thr};
      REG_LVL1:     cfg_prdata = {16'd0, thr_r.lvl1_thr};
      REG_NAV_MODE: cfg_prdata = {31'd0, nav_mode_r};
      REG_FAR:      cfg_prdata = {16'd0, nav_cfg_r.far_dist};
      REG_MID:      cfg_prdata = {16'd0, nav_cfg_r.mid_dist};
      REG_STOP:     cfg_prdata = {16'd0, nav_cfg_r.stop_dist};
      default:      cfg_prdata = '0;
    endcase
  end

  // grading lanes
  assign lane_dist[LANE_FRONT] = in_front_distance_cm;
  assign lane_dist[LANE_LEFT]  = in_left_distance_cm;
  assign lane_dist[LANE_RIGHT] = in_right_distance_cm;
  assign lane_dist[LANE_BACK]  = in_back_distance_cm;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    osd_grade_lane u_lane (
      .dist_cm (lane_dist[g]),
      .thr     (thr_r),
      .lvl     (lane_lvl[g])
    );
  end

  assign lvls.front = lane_lvl[LANE_FRONT];
  assign lvls.left  = lane_lvl[LANE_LEFT];
  assign lvls.right = lane_lvl[LANE_RIGHT];
  assign lvls.back  = lane_lvl[LANE_BACK];

  osd_nav u_nav (
    .heading (in_target_heading_deg),
    .bearing (in_current_bearing_deg),
    .dist_m  (in_target_distance_m),
    .cfg     (nav_cfg_r),
    .drive   (nav_drive)
  );

  // pipeline control
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= in_valid;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_lvls_r   <= lvls;
      s1_nav_r    <= nav_drive;
      out_drive_r <= mrg_drive;
      out_flags_r <= mrg_flags;
    end
  end

  osd_merge u_merge (
    .lvls     (s1_lvls_r),
    .nav      (s1_nav_r),
    .nav_mode (nav_mode_r),
    .drive    (mrg_drive),
    .flags    (mrg_flags)
  );

  assign out_valid          = out_valid_r;
  assign out_speed_code     = out_drive_r.speed;
  assign out_steer_code     = out_drive_r.steer;
  assign out_obstacle_flags = out_flags_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with empty output register");

  a_accept_reaches_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> s1_valid_r)
    else $error("accepted transaction lost before stage one");

  a_s1_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && advance |=> out_valid_r)
    else $error("stage one transaction lost before output");

  a_reverse_steers_right: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_drive_r.speed == SPD_REVERSE |-> out_drive_r.steer == STR_MED_RIGHT)
    else $error("reverse without medium right steer");

  a_no_reverse_when_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_flags_r[2:0] == 3'b000 |-> out_drive_r.speed != SPD_REVERSE)
    else $error("reverse with front, left and right clear");

endmodule

`default_nettype wire
